@@ rtl/dq_pkg.sv @@
// Package for the double-ended queue: sizes, operation and status codes,
// request and response payload types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_READ_FWD   = 3'd4;
   localparam logic [2:0] OP_READ_REV   = 3'd5;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [2:0]                operation;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  value_out;
      logic [1:0]                status;
      logic                      last;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/dq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/double_ended_queue.sv @@
// Double-ended queue of signed 32-bit values over a ring buffer in one RAM.
// Uses dq_pkg and dq_ram.
//
// Requests arrive on req_valid / req_stall / req_data, results leave on
// rsp_valid / rsp_stall / rsp_data, both accepted when valid is high and
// stall is low. Push and pop requests give one status result, registered
// in the cycle after the request is taken; the next request can be taken
// in the following cycle, so pushes and pops run at one request per cycle
// while the receiver does not stall. A read-out streams one result per
// stored entry, front to back or back to front, with last set on the final
// one. The RAM read is pipelined through the RAM read register and the result
// register, then gives one entry a cycle while the receiver does not stall;
// req_stall stays high until the last entry is out. An empty read-out gives
// a single empty status. Operation codes 6 and 7 are taken and give no result.
// While the receiver stalls, the result register holds its value, the RAM
// read stream pauses once a read word is pending and req_stall stays high.
// Reset clears the front pointer, the count and all handshake state; the
// RAM contents are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire dq_pkg::req_type req_data,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      dq_pkg::rsp_type rsp_data
);

   localparam int IW = dq_pkg::IDX_W;
   localparam int CW = dq_pkg::CNT_W;

   dq_pkg::state_type state_ff, state_in;
   logic [IW-1:0]     front_ff, front_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              rd_rev_ff, rd_rev_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dq_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              req_take;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic [IW-1:0]     rd_off;
   logic [IW:0]       rd_sum;
   logic [dq_pkg::DATA_W-1:0] rd_data;
   logic              q_full;
   logic              q_empty;
   logic              issue_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == dq_pkg::ST_IDLE) && out_free);
   assign req_take = req_valid && !req_stall;
   assign q_full = (occ_ff == CW'(dq_pkg::DEPTH));
   assign q_empty = (occ_ff == '0);

   // ring slot for the current read-out offset
   always_comb begin
      if (rd_rev_ff) begin
         rd_off = IW'(occ_ff - CW'(1) - rd_cnt_ff);
      end else begin
         rd_off = rd_cnt_ff[IW-1:0];
      end
      rd_sum = {1'b0, front_ff} + {1'b0, rd_off};
      if (rd_sum >= (IW+1)'(dq_pkg::DEPTH)) begin
         rd_addr = IW'(rd_sum - (IW+1)'(dq_pkg::DEPTH));
      end else begin
         rd_addr = rd_sum[IW-1:0];
      end
   end

   assign rd_en = (state_ff == dq_pkg::ST_READ) && (rd_cnt_ff != occ_ff)
                  && (!pend_ff || out_free);
   assign issue_last = ((rd_cnt_ff + CW'(1)) == occ_ff);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      occ_in       = occ_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_rev_in    = rd_rev_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;

      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (req_take) begin
               rsp_data_in.value_out = '0;
               rsp_data_in.status    = dq_pkg::STATUS_OK;
               rsp_data_in.last      = 1'b1;
               rsp_valid_in          = 1'b1;
               unique case (req_data.operation)
                  dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
                     if (q_full) begin
                        rsp_data_in.status = dq_pkg::STATUS_FULL;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + CW'(1);
                        if (req_data.operation == dq_pkg::OP_PUSH_FRONT) begin
                           if (front_ff == '0) begin
                              front_in = IW'(dq_pkg::DEPTH - 1);
                           end else begin
                              front_in = front_ff - IW'(1);
                           end
                           wr_addr = front_in;
                        end else begin
                           if (({1'b0, front_ff} + {1'b0, occ_ff[IW-1:0]})
                               >= (IW+1)'(dq_pkg::DEPTH)) begin
                              wr_addr = IW'({1'b0, front_ff} + {1'b0, occ_ff[IW-1:0]}
                                            - (IW+1)'(dq_pkg::DEPTH));
                           end else begin
                              wr_addr = front_ff + occ_ff[IW-1:0];
                           end
                        end
                     end
                  end
                  dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
                     if (q_empty) begin
                        rsp_data_in.status = dq_pkg::STATUS_EMPTY;
                     end else begin
                        occ_in = occ_ff - CW'(1);
                        if (req_data.operation == dq_pkg::OP_POP_FRONT) begin
                           if (front_ff == IW'(dq_pkg::DEPTH - 1)) begin
                              front_in = '0;
                           end else begin
                              front_in = front_ff + IW'(1);
                           end
                        end
                     end
                  end
                  dq_pkg::OP_READ_FWD, dq_pkg::OP_READ_REV: begin
                     if (q_empty) begin
                        rsp_data_in.status = dq_pkg::STATUS_EMPTY;
                     end else begin
                        // results come from the read stream instead
                        rsp_valid_in = 1'b0;
                        state_in     = dq_pkg::ST_READ;
                        rd_cnt_in    = '0;
                        rd_rev_in    = (req_data.operation == dq_pkg::OP_READ_REV);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         dq_pkg::ST_READ: begin
            if (pend_ff && out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.value_out = rd_data;
               rsp_data_in.status    = dq_pkg::STATUS_OK;
               rsp_data_in.last      = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = dq_pkg::ST_IDLE;
               end
            end
            if (rd_en) begin
               rd_cnt_in    = rd_cnt_ff + CW'(1);
               pend_in      = 1'b1;
               pend_last_in = issue_last;
            end else if (pend_ff && out_free) begin
               pend_in = 1'b0;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rd_cnt_ff    <= '0;
         rd_rev_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_rev_ff    <= rd_rev_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   dq_ram #(
      .WIDTH (dq_pkg::DATA_W),
      .DEPTH (dq_pkg::DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(dq_pkg::DEPTH))
      else $error("occupancy above depth");

   a_pend_in_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == dq_pkg::ST_READ))
      else $error("pending read data outside read-out");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("RAM write and read in the same cycle");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_take |-> out_free)
      else $error("request taken while result register is stalled");

   a_last_ends_read: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && out_free && pend_last_ff) |=> (state_ff == dq_pkg::ST_IDLE)
                                                && rsp_valid_ff && rsp_data_ff.last)
      else $error("read-out did not close on its last entry");

endmodule

`default_nettype wire
